// ===== src/gregorian_date_add_days_unit_assert.svh =====
// assertion macros for the checker file of the date adder
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, idle during reset
`define GDAD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gdad check failed");

// next-cycle implication, sampled on clk, idle during reset
`define GDAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gdad check failed");

`endif

// ===== src/gdad_pkg.sv =====
// types, constants and month length lookup for the date adder
package gdad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [YEAR_W-1:0] CYCLE_400   = 14'd400;
  localparam logic [YEAR_W-1:0] CYCLE_LAST  = 14'd399;
  localparam logic [YEAR_W-1:0] CENTURY_1   = 14'd100;
  localparam logic [YEAR_W-1:0] CENTURY_2   = 14'd200;
  localparam logic [YEAR_W-1:0] CENTURY_3   = 14'd300;
  localparam logic [YEAR_W-1:0] YEAR_TOP    = 14'h3FFF;

  localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
  localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic sub400;
    logic step;
  } gdad_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rem_ge_400;
    logic total_gt_len;
  } gdad_status_t;

  // days in a month, february by leap flag
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MONTH_FEB: len = leap ? LEN_29 : LEN_28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
      default: len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/gdad_dp.sv =====
// datapath: day total, month, year and year-mod-400 registers
module gdad_dp #(
  parameter int DAYS_WIDTH = 16
) (
  input  logic                          clk,
  input  gdad_pkg::gdad_cmd_t           cmd,
  input  logic [gdad_pkg::DAY_W-1:0]    start_day,
  input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
  input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
  input  logic [DAYS_WIDTH-1:0]         days_to_add,
  output gdad_pkg::gdad_status_t        status,
  output logic [gdad_pkg::DAY_W-1:0]    end_day,
  output logic [gdad_pkg::MONTH_W-1:0]  end_month,
  output logic [gdad_pkg::YEAR_W-1:0]   end_year
);
  import gdad_pkg::*;

  localparam int TOTAL_W = DAYS_WIDTH + 1;

  logic [TOTAL_W-1:0] day_total;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [YEAR_W-1:0]  year_rem;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic [MONTH_W-1:0] month_clamped;

  // leap year from year mod 400
  always_comb begin
    leap = (year_rem[1:0] == 2'b00) &&
           !(year_rem inside {CENTURY_1, CENTURY_2, CENTURY_3});
    len  = month_len(month, leap);
  end

  // out-of-range start months fold to january or december
  always_comb begin
    if (start_month == '0) begin
      month_clamped = MONTH_JAN;
    end else if (start_month > MONTH_DEC) begin
      month_clamped = MONTH_DEC;
    end else begin
      month_clamped = start_month;
    end
  end

  // load, reduce year mod 400, then walk one month per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_total <= TOTAL_W'(start_day) + TOTAL_W'(days_to_add);
      month     <= month_clamped;
      year      <= start_year;
      year_rem  <= start_year;
    end else if (cmd.sub400) begin
      year_rem <= year_rem - CYCLE_400;
    end else if (cmd.step) begin
      day_total <= day_total - TOTAL_W'(len);
      if (month == MONTH_DEC) begin
        month <= MONTH_JAN;
        year  <= year + YEAR_W'(1);
        // the 14-bit year wraps to 0, which restarts the 400-year period
        if (year == YEAR_TOP || year_rem == CYCLE_LAST) begin
          year_rem <= '0;
        end else begin
          year_rem <= year_rem + YEAR_W'(1);
        end
      end else begin
        month <= month + MONTH_W'(1);
      end
    end
  end

  // status and result
  always_comb begin
    status.rem_ge_400   = (year_rem >= CYCLE_400);
    status.total_gt_len = (day_total > TOTAL_W'(len));
    end_day   = day_total[DAY_W-1:0];
    end_month = month;
    end_year  = year;
  end

endmodule

// ===== src/gdad_ctrl.sv =====
// controller: sequences the year reduction and the month walk
module gdad_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  gdad_pkg::gdad_status_t status,
  output gdad_pkg::gdad_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);
  import gdad_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WALK
  } state_t;

  state_t state;

  // commands decoded from state and status
  always_comb begin
    cmd.load   = (state == ST_IDLE) && start;
    cmd.sub400 = (state == ST_REDUCE) && status.rem_ge_400;
    cmd.step   = (state == ST_WALK) && status.total_gt_len;
  end

  // state and registered busy/done
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_REDUCE;
            busy  <= 1'b1;
          end
        end
        ST_REDUCE: begin
          if (!status.rem_ge_400) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!status.total_gt_len) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/gregorian_date_add_days_unit.sv =====
// top level of the gregorian date adder
//
// Usage: drive start_day, start_month, start_year and days_to_add and raise
// start; the request is taken at a rising edge where start is high and busy
// is low. busy rises the next cycle and stays high while the request works.
// The result appears on end_day, end_month and end_year with done high for
// exactly one cycle; busy is low in that same cycle, so a new request may be
// taken at the edge that ends it. The result ports hold their value until
// the next request is taken.
// Steps: load, then the year reduction, which subtracts 400 from the year
// remainder until it is below 400, then the month walk, which subtracts one
// month length per cycle and advances the month until the day total fits.
// One request is in flight at a time.
// Reset (rst, synchronous) returns the controller to idle with busy and done
// low. done cannot be held off: the receiver must take each result as shown.
module gregorian_date_add_days_unit #(
  parameter int DAYS_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [gdad_pkg::DAY_W-1:0]    start_day,
  input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
  input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
  input  logic [DAYS_WIDTH-1:0]         days_to_add,
  output logic [gdad_pkg::DAY_W-1:0]    end_day,
  output logic [gdad_pkg::MONTH_W-1:0]  end_month,
  output logic [gdad_pkg::YEAR_W-1:0]   end_year
);
  import gdad_pkg::*;

  gdad_cmd_t    cmd;
  gdad_status_t status;
  logic         start_ok;

  // only present start to the controller when idle
  assign start_ok = start && !busy;

  // controller
  gdad_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start_ok),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // datapath
  gdad_dp #(
    .DAYS_WIDTH (DAYS_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .days_to_add (days_to_add),
    .status      (status),
    .end_day     (end_day),
    .end_month   (end_month),
    .end_year    (end_year)
  );

endmodule

// ===== src/gdad_checker.sv =====
// port-level checks for the date adder, bound to the top level
`include "gregorian_date_add_days_unit_assert.svh"

module gdad_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [gdad_pkg::MONTH_W-1:0] end_month
);
  import gdad_pkg::*;

  // a taken request makes the unit busy
  `GDAD_ASSERT_NEXT(a_take_busy, start && !busy, busy)
  // the result strobe comes with busy already dropped
  `GDAD_ASSERT_SAME(a_done_idle, done, !busy)
  // busy only drops when a result is shown
  `GDAD_ASSERT_SAME(a_fall_done, $fell(busy), done)
  // result strobe lasts one cycle
  `GDAD_ASSERT_NEXT(a_done_pulse, done, !done)
  // every result month is a real month
  `GDAD_ASSERT_SAME(a_month_ok, done, (end_month >= MONTH_JAN) && (end_month <= MONTH_DEC))

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (.*);
